### hdl/ffsa_pkg.sv
// shared types, constants and command/status structs for the first-fit allocator
// no dependencies; imported by every module in hdl/
package ffsa_pkg;

    localparam int ARENA_BYTES  = 4096;
    localparam int HEADER_BYTES = 24;
    localparam int MAX_SEGMENTS = 256;

    localparam int IDX_W  = $clog2(MAX_SEGMENTS);
    localparam int CNT_W  = IDX_W + 1;
    localparam int SIZE_W = $clog2(ARENA_BYTES);
    localparam int POS_W  = SIZE_W + 1;
    localparam int REQ_W  = 13;
    localparam int OFF_W  = 13;
    localparam int GNT_W  = 12;
    localparam int STS_W  = 2;
    localparam int CMP_W  = REQ_W + 1;
    localparam int SUM_W  = SIZE_W + 2;

    localparam logic [STS_W-1:0] ST_DONE    = STS_W'(0);
    localparam logic [STS_W-1:0] ST_NOSPACE = STS_W'(1);
    localparam logic [STS_W-1:0] ST_BADOFF  = STS_W'(2);

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [SIZE_W-1:0] INIT_SIZE = SIZE_W'(ARENA_BYTES - HEADER_BYTES);
    localparam logic [POS_W-1:0]  HDR_POS   = POS_W'(HEADER_BYTES);
    localparam logic [SUM_W-1:0]  HDR_SUM   = SUM_W'(HEADER_BYTES);
    localparam logic [CMP_W-1:0]  HDR_CMP   = CMP_W'(HEADER_BYTES);
    localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_SEGMENTS);

    typedef struct packed {
        logic             func;
        logic [REQ_W-1:0] request_bytes;
        logic [OFF_W-1:0] payload_offset;
    } ffsa_in_t;

    typedef struct packed {
        logic [STS_W-1:0] status;
        logic [GNT_W-1:0] granted_offset;
    } ffsa_out_t;

    typedef struct packed {
        logic              free;
        logic [SIZE_W-1:0] size;
    } seg_t;

    typedef enum logic [3:0] {
        DP_NOP, DP_INIT, DP_LOAD, DP_SCAN_RD, DP_SCAN_EX, DP_FAIL,
        DP_SHU_RD, DP_SHU_WR, DP_SPLIT_W1, DP_SPLIT_W2,
        DP_NXT_RD, DP_NXT_EX, DP_MRG_W, DP_SHD_RD, DP_SHD_WR, DP_COMMIT
    } dp_op_t;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_SCAN_RD, S_SCAN_EX, S_SHU_RD, S_SHU_WR,
        S_SPLIT_W1, S_SPLIT_W2, S_NXT_RD, S_NXT_EX, S_MRG_W,
        S_SHD_RD, S_SHD_WR, S_DONE
    } fsm_state_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic func_free;
        logic scan_end;
        logic fit_exact;
        logic fit_split;
        logic off_match;
        logic next_exists;
        logic shu_done;
        logic shd_done;
        logic out_free;
    } dp_stat_t;

endpackage

### hdl/ffsa_ctrl.sv
// sequencer for the allocator: scan, shift-up split, merge and shift-down
// depends on ffsa_pkg
module ffsa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ffsa_pkg::dp_stat_t stat,
    output ffsa_pkg::dp_cmd_t  cmd
);
    import ffsa_pkg::*;

    fsm_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.op     = DP_NOP;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_INIT: begin
                cmd.op     = DP_INIT;
                state_next = S_IDLE;
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = DP_LOAD;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (stat.scan_end) begin
                    cmd.op     = DP_FAIL;
                    state_next = S_DONE;
                end else begin
                    cmd.op     = DP_SCAN_RD;
                    state_next = S_SCAN_EX;
                end
            end
            S_SCAN_EX: begin
                cmd.op = DP_SCAN_EX;
                if (stat.func_free) begin
                    if (stat.off_match) begin
                        state_next = stat.next_exists ? S_NXT_RD : S_MRG_W;
                    end else begin
                        state_next = S_SCAN_RD;
                    end
                end else if (stat.fit_exact) begin
                    state_next = S_DONE;
                end else if (stat.fit_split) begin
                    state_next = S_SHU_RD;
                end else begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SHU_RD: begin
                if (stat.shu_done) begin
                    state_next = S_SPLIT_W1;
                end else begin
                    cmd.op     = DP_SHU_RD;
                    state_next = S_SHU_WR;
                end
            end
            S_SHU_WR: begin
                cmd.op     = DP_SHU_WR;
                state_next = S_SHU_RD;
            end
            S_SPLIT_W1: begin
                cmd.op     = DP_SPLIT_W1;
                state_next = S_SPLIT_W2;
            end
            S_SPLIT_W2: begin
                cmd.op     = DP_SPLIT_W2;
                state_next = S_DONE;
            end
            S_NXT_RD: begin
                cmd.op     = DP_NXT_RD;
                state_next = S_NXT_EX;
            end
            S_NXT_EX: begin
                cmd.op     = DP_NXT_EX;
                state_next = S_MRG_W;
            end
            S_MRG_W: begin
                cmd.op     = DP_MRG_W;
                state_next = S_SHD_RD;
            end
            S_SHD_RD: begin
                if (stat.shd_done) begin
                    state_next = S_DONE;
                end else begin
                    cmd.op     = DP_SHD_RD;
                    state_next = S_SHD_WR;
                end
            end
            S_SHD_WR: begin
                cmd.op     = DP_SHD_WR;
                state_next = S_SHD_RD;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.op     = DP_COMMIT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### hdl/ffsa_dp.sv
// datapath: segment table memory, scan position, shift pointers, result register
// depends on ffsa_pkg
module ffsa_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  ffsa_pkg::ffsa_in_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output ffsa_pkg::ffsa_out_t m_payload,
    input  ffsa_pkg::dp_cmd_t   cmd,
    output ffsa_pkg::dp_stat_t  stat
);
    import ffsa_pkg::*;

    seg_t mem [MAX_SEGMENTS];
    seg_t rd_data_reg;

    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    seg_t              wr_data;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  j_reg;
    logic [POS_W-1:0]  pos_reg;
    seg_t              prev_reg;
    logic              func_reg;
    logic [REQ_W-1:0]  req_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [IDX_W-1:0]  base_reg;
    logic [SIZE_W-1:0] acc_reg;
    logic [1:0]        rem_reg;
    seg_t              cur_reg;
    ffsa_out_t         res_reg;
    ffsa_out_t         out_reg;
    logic              out_valid_reg;

    seg_t              d;
    logic [POS_W-1:0]  pos_hdr;
    logic [POS_W-1:0]  pos_adv;
    logic [CNT_W-1:0]  idx_p1;
    logic [CNT_W-1:0]  j_m1;
    logic [CNT_W-1:0]  j_rem;
    logic [CMP_W-1:0]  size_cmp;
    logic [CMP_W-1:0]  req_cmp;
    logic [SIZE_W-1:0] split_rest;
    logic [SUM_W-1:0]  merge_prev;
    logic [SUM_W-1:0]  merge_next;

    assign d          = rd_data_reg;
    assign pos_hdr    = pos_reg + HDR_POS;
    assign pos_adv    = pos_hdr + POS_W'(d.size);
    assign idx_p1     = idx_reg + CNT_W'(1);
    assign j_m1       = j_reg - CNT_W'(1);
    assign j_rem      = j_reg + CNT_W'(rem_reg);
    assign size_cmp   = CMP_W'(d.size);
    assign req_cmp    = CMP_W'(req_reg);
    assign split_rest = SIZE_W'(CMP_W'(cur_reg.size) - req_cmp - HDR_CMP);
    assign merge_prev = SUM_W'(prev_reg.size) + HDR_SUM + SUM_W'(d.size);
    assign merge_next = SUM_W'(acc_reg) + HDR_SUM + SUM_W'(d.size);

    assign stat.func_free   = func_reg == FUNC_FREE;
    assign stat.scan_end    = idx_reg == count_reg;
    assign stat.fit_exact   = d.free && (size_cmp == req_cmp);
    assign stat.fit_split   = d.free && (size_cmp > req_cmp + HDR_CMP) && (count_reg < MAX_CNT);
    assign stat.off_match   = OFF_W'(pos_hdr) == off_reg;
    assign stat.next_exists = idx_p1 < count_reg;
    assign stat.shu_done    = j_reg == idx_p1;
    assign stat.shd_done    = (rem_reg == 2'd0) || (j_reg >= count_reg);
    assign stat.out_free    = !out_valid_reg || m_ready;

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

    // read address per step
    always_comb begin
        unique case (cmd.op)
            DP_SHU_RD: rd_addr = j_m1[IDX_W-1:0];
            DP_NXT_RD: rd_addr = idx_p1[IDX_W-1:0];
            DP_SHD_RD: rd_addr = j_rem[IDX_W-1:0];
            default:   rd_addr = idx_reg[IDX_W-1:0];
        endcase
    end

    // write port per step
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = idx_reg[IDX_W-1:0];
        wr_data = d;
        unique case (cmd.op) inside
            DP_INIT: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = '{free: 1'b1, size: INIT_SIZE};
            end
            DP_SCAN_EX: begin
                if (func_reg == FUNC_ALLOC && stat.fit_exact) begin
                    wr_en   = 1'b1;
                    wr_data = '{free: 1'b0, size: d.size};
                end
            end
            DP_SHU_WR, DP_SHD_WR: begin
                wr_en   = 1'b1;
                wr_addr = j_reg[IDX_W-1:0];
            end
            DP_SPLIT_W1: begin
                wr_en   = 1'b1;
                wr_addr = idx_p1[IDX_W-1:0];
                wr_data = '{free: 1'b1, size: split_rest};
            end
            DP_SPLIT_W2: begin
                wr_en   = 1'b1;
                wr_data = '{free: 1'b0, size: req_reg[SIZE_W-1:0]};
            end
            DP_MRG_W: begin
                wr_en   = 1'b1;
                wr_addr = base_reg;
                wr_data = '{free: 1'b1, size: acc_reg};
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            DP_LOAD: begin
                func_reg      <= s_payload.func;
                req_reg       <= s_payload.request_bytes;
                off_reg       <= s_payload.payload_offset;
                idx_reg       <= '0;
                pos_reg       <= '0;
                prev_reg.free <= 1'b0;
            end
            DP_SCAN_EX: begin
                if (func_reg == FUNC_FREE) begin
                    if (stat.off_match) begin
                        cur_reg <= d;
                        if (prev_reg.free) begin
                            base_reg <= IDX_W'(idx_reg - CNT_W'(1));
                            acc_reg  <= SIZE_W'(merge_prev);
                            rem_reg  <= 2'd1;
                        end else begin
                            base_reg <= idx_reg[IDX_W-1:0];
                            acc_reg  <= d.size;
                            rem_reg  <= 2'd0;
                        end
                    end else begin
                        pos_reg  <= pos_adv;
                        prev_reg <= d;
                        idx_reg  <= idx_p1;
                    end
                end else if (stat.fit_exact) begin
                    res_reg <= '{status: ST_DONE, granted_offset: pos_hdr[GNT_W-1:0]};
                end else if (stat.fit_split) begin
                    cur_reg <= d;
                    j_reg   <= count_reg;
                end else begin
                    pos_reg  <= pos_adv;
                    prev_reg <= d;
                    idx_reg  <= idx_p1;
                end
            end
            DP_FAIL: begin
                res_reg <= '{status: (func_reg == FUNC_FREE) ? ST_BADOFF : ST_NOSPACE,
                             granted_offset: '0};
            end
            DP_SHU_WR: j_reg <= j_m1;
            DP_SHD_WR: j_reg <= j_reg + CNT_W'(1);
            DP_SPLIT_W2: begin
                res_reg <= '{status: ST_DONE, granted_offset: pos_hdr[GNT_W-1:0]};
            end
            DP_NXT_EX: begin
                if (d.free) begin
                    acc_reg <= SIZE_W'(merge_next);
                    rem_reg <= rem_reg + 2'd1;
                end
            end
            DP_MRG_W: begin
                j_reg   <= CNT_W'(base_reg) + CNT_W'(1);
                res_reg <= '{status: ST_DONE, granted_offset: '0};
            end
            DP_COMMIT: out_reg <= res_reg;
            default: begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= CNT_W'(1);
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.op == DP_INIT) begin
                count_reg <= CNT_W'(1);
            end else if (cmd.op == DP_SPLIT_W2) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (cmd.op == DP_MRG_W) begin
                count_reg <= count_reg - CNT_W'(rem_reg);
            end
            if (cmd.op == DP_COMMIT) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

### hdl/first_fit_segment_allocator.sv
// top level of the first-fit segment allocator
// depends on ffsa_pkg, ffsa_ctrl and ffsa_dp
//
// First-fit allocator over a 4096-byte arena kept as an address-ordered table of
// up to 256 segments (24-byte header each) in a single-port-write, registered-read
// memory. An allocate (func 0) takes the first free segment that fits exactly
// or, while the table has room, is larger than request plus a header and is
// split; a free (func 1) must name an exact payload start and merges with free
// neighbors. One item is handled at a time: the scan visits segments in order
// (memory read then evaluate), a split moves each later segment up and a free
// moves later segments down. After reset, the init state writes the initial
// free segment before the first item is taken. The result sits in an output
// register, so a new item can start while the last result waits.
module first_fit_segment_allocator (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ffsa_pkg::ffsa_in_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output ffsa_pkg::ffsa_out_t m_payload
);
    import ffsa_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer
    ffsa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // table memory and arithmetic
    ffsa_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

### verif/testbench.sv
// self-checking testbench for the first-fit segment allocator
// depends on ffsa_pkg and first_fit_segment_allocator; drives random allocate/free items

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ffsa_pkg::*;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    ffsa_in_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    ffsa_out_t m_payload;

    first_fit_segment_allocator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload)
    );

    always #2 aclk = ~aclk;

    // shadow copy of the segment table
    int unsigned seg_len[MAX_SEGMENTS];
    bit          seg_avail[MAX_SEGMENTS];
    int unsigned live_segs;

    ffsa_in_t  pending_items[$];
    ffsa_out_t expected_grants[$];
    int unsigned errors = 0;
    int unsigned cycles = 0;
    bit          tail_phase = 1'b0;
    bit          stim_done = 1'b0;
    int unsigned hold_off = 0;
    int unsigned send_gap = 0;
    int unsigned recv_gap = 0;
    int unsigned accepted_cnt = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic void table_reset();
        for (int i = 0; i < MAX_SEGMENTS; i++) begin
            seg_len[i] = 0;
            seg_avail[i] = 1'b0;
        end
        seg_len[0] = ARENA_BYTES - HEADER_BYTES;
        seg_avail[0] = 1'b1;
        live_segs = 1;
    endfunction

    function automatic void coalesce_free();
        int unsigned i;
        i = 0;
        while (i + 1 < live_segs) begin
            if (seg_avail[i] && seg_avail[i+1]) begin
                seg_len[i] += seg_len[i+1] + HEADER_BYTES;
                for (int j = i + 1; j + 1 < live_segs; j++) begin
                    seg_len[j] = seg_len[j+1];
                    seg_avail[j] = seg_avail[j+1];
                end
                live_segs--;
                seg_len[live_segs] = 0;
                seg_avail[live_segs] = 1'b0;
            end else begin
                i++;
            end
        end
    endfunction

    function automatic ffsa_out_t predict_grant(input ffsa_in_t it);
        ffsa_out_t   r;
        int unsigned pos;
        int unsigned req;
        int unsigned sz;
        bit          hit;
        r = '0;
        pos = 0;
        hit = 1'b0;
        if (it.func == FUNC_ALLOC) begin
            req = it.request_bytes;
            for (int i = 0; i < live_segs && !hit; i++) begin
                sz = seg_len[i];
                if (seg_avail[i] && sz == req) begin
                    seg_avail[i] = 1'b0;
                    hit = 1'b1;
                end else if (seg_avail[i] && sz > req + HEADER_BYTES
                             && live_segs < MAX_SEGMENTS) begin
                    for (int j = live_segs; j > i + 1; j--) begin
                        seg_len[j] = seg_len[j-1];
                        seg_avail[j] = seg_avail[j-1];
                    end
                    seg_len[i+1] = sz - req - HEADER_BYTES;
                    seg_avail[i+1] = 1'b1;
                    seg_len[i] = req;
                    seg_avail[i] = 1'b0;
                    live_segs++;
                    hit = 1'b1;
                end
                if (hit) r.granted_offset = GNT_W'(pos + HEADER_BYTES);
                else pos += HEADER_BYTES + sz;
            end
            r.status = hit ? ST_DONE : ST_NOSPACE;
        end else begin
            for (int i = 0; i < live_segs && !hit; i++) begin
                if (pos + HEADER_BYTES == it.payload_offset) begin
                    seg_avail[i] = 1'b1;
                    coalesce_free();
                    hit = 1'b1;
                end
                pos += HEADER_BYTES + seg_len[i];
            end
            r.status = hit ? ST_DONE : ST_BADOFF;
        end
        return r;
    endfunction

    // payload starts of live segments, used to aim frees at real offsets
    function automatic int unsigned pick_start();
        int unsigned pos;
        int unsigned k;
        pos = 0;
        k = $urandom_range(0, live_segs - 1);
        for (int i = 0; i < k; i++) pos += HEADER_BYTES + seg_len[i];
        return pos + HEADER_BYTES;
    endfunction

    // driver: items leave the queue, valid held until accepted
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_grants.push_back(predict_grant(s_payload));
                accepted_cnt++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    s_payload <= pending_items.pop_front();
                    s_valid <= 1'b1;
                    if (!tail_phase && $urandom_range(0, 7) == 0)
                        send_gap <= $urandom_range(1, 12);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result with the oldest expectation
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_grants.size() == 0) begin
                    report_mismatch("unexpected item", m_payload.status, -1);
                end else begin
                    ffsa_out_t e;
                    e = expected_grants.pop_front();
                    if (m_payload.status !== e.status)
                        report_mismatch("status", m_payload.status, e.status);
                    if (m_payload.granted_offset !== e.granted_offset)
                        report_mismatch("granted_offset", m_payload.granted_offset,
                                        e.granted_offset);
                end
            end
            // long hold-off near the start so the block backs up its input
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!tail_phase && $urandom_range(0, 7) == 0)
                    recv_gap <= $urandom_range(1, 12);
            end
        end
    end

    // stimulus: mirror table tracks frees aimed at live starts
    ffsa_in_t mk;
    initial begin
        table_reset();
        hold_off = 400;
        // directed: zero byte, exact fit, full arena, extremes, bad and double free
        mk = '0; mk.func = FUNC_ALLOC; mk.request_bytes = 0;     pending_items.push_back(mk);
        mk.request_bytes = 13'h1FFF;                             pending_items.push_back(mk);
        mk.request_bytes = 100;                                  pending_items.push_back(mk);
        mk.func = FUNC_FREE; mk.payload_offset = 13'h1FFF;       pending_items.push_back(mk);
        mk.payload_offset = 0;                                   pending_items.push_back(mk);
        mk.payload_offset = 48;                                  pending_items.push_back(mk);
        mk.payload_offset = 48;                                  pending_items.push_back(mk);
        mk.payload_offset = 24;                                  pending_items.push_back(mk);
        mk.func = FUNC_ALLOC; mk.request_bytes = REQ_W'(ARENA_BYTES - HEADER_BYTES);
        pending_items.push_back(mk);
        mk.request_bytes = REQ_W'(ARENA_BYTES - HEADER_BYTES - 1);
        pending_items.push_back(mk);
        mk.func = FUNC_FREE; mk.payload_offset = 24;             pending_items.push_back(mk);
        // a short run of zero-size segments
        mk.func = FUNC_ALLOC; mk.request_bytes = 0;
        for (int i = 0; i < 10; i++) pending_items.push_back(mk);
        mk.payload_offset = 13'h1555; mk.request_bytes = 13'h0AAA; pending_items.push_back(mk);
        mk.payload_offset = 13'h0AAA; mk.request_bytes = 13'h1555;
        mk.func = FUNC_FREE;                                     pending_items.push_back(mk);
        // run the directed items through the shadow table so frees can be aimed
        foreach (pending_items[i]) void'(predict_grant(pending_items[i]));
        for (int n = 0; n < 1170; n++) begin
            int unsigned pick;
            mk.request_bytes = REQ_W'($urandom_range(0, 8191));
            mk.payload_offset = OFF_W'($urandom_range(0, 8191));
            pick = $urandom_range(0, 99);
            if (n > 300 && n < 500) begin
                // many zero/tiny allocs to push the table to its limit
                mk.func = (pick < 85) ? FUNC_ALLOC : FUNC_FREE;
                mk.request_bytes = REQ_W'($urandom_range(0, 2));
                if (mk.func == FUNC_FREE) mk.payload_offset = OFF_W'(pick_start());
            end else if (pick < 50) begin
                mk.func = FUNC_ALLOC;
                if (pick < 40) mk.request_bytes = REQ_W'($urandom_range(0, 300));
            end else begin
                mk.func = FUNC_FREE;
                if (pick < 92) mk.payload_offset = OFF_W'(pick_start());
            end
            void'(predict_grant(mk));
            pending_items.push_back(mk);
            if (n == 900) tail_phase = 1'b0;
        end
        table_reset();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        wait (accepted_cnt > 900);
        tail_phase = 1'b1;
        wait (pending_items.size() == 0 && !s_valid);
        wait (expected_grants.size() == 0);
        repeat (50) @(posedge aclk);
        stim_done = 1'b1;
    end

    // end of run
    initial begin
        wait (stim_done || cycles > 3000000);
        if (!stim_done) begin
            $display("SCOREBOARD MISMATCH");
        end else if (errors == 0 && expected_grants.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/ffsa_pkg.sv
hdl/ffsa_ctrl.sv
hdl/ffsa_dp.sv
hdl/first_fit_segment_allocator.sv
verif/testbench.sv
